// File: src/triangle_face_normal_macros.svh
// Assertion helpers shared by the face normal RTL.
// Both expect i_clk and i_rst_n in the enclosing module.
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TFN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TFN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tfn_pkg.sv
package tfn_pkg;

    // default widths
    localparam int TFN_COORD_BITS       = 16;
    localparam int TFN_NORMAL_FRAC_BITS = 14;

    // sideband that travels with each word through a normalize lane
    typedef struct packed {
        logic valid;
        logic neg;     // cross component was negative
        logic degen;   // all cross components zero
    } t_lane_tag;

endpackage

// File: src/tfn_tri_if.sv
interface tfn_tri_if import tfn_pkg::*; #(
    parameter int COORD_BITS = TFN_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

// File: src/tfn_norm_if.sv
interface tfn_norm_if import tfn_pkg::*; #(
    parameter int NORMAL_FRAC_BITS = TFN_NORMAL_FRAC_BITS
) ();
    logic                               valid;
    logic                               ready;
    logic signed [NORMAL_FRAC_BITS+1:0] nx;
    logic signed [NORMAL_FRAC_BITS+1:0] ny;
    logic signed [NORMAL_FRAC_BITS+1:0] nz;
    logic                               degenerate;

    modport source (output valid, nx, ny, nz, degenerate, input ready);
    modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface

// File: src/tfn_norm_lane.sv
`include "triangle_face_normal_macros.svh"

// One normal component: q = round(c * 2^F / sqrt(S)).
// m = isqrt(floor(c^2 * 2^(2F+2) / S)), q = (m + 1) >> 1.
// Restoring divide, one quotient bit per stage, then a digit-by-digit
// square root, one root bit per stage, then round and sign.
module tfn_norm_lane import tfn_pkg::*; #(
    parameter int COORD_BITS       = TFN_COORD_BITS,
    parameter int NORMAL_FRAC_BITS = TFN_NORMAL_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  t_lane_tag                           i_tag,
    input  logic [2*(2*COORD_BITS+1)-1:0]       i_csq,
    input  logic [2*(2*COORD_BITS+1)+1:0]       i_len_sq,
    output t_lane_tag                           o_tag,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_q
);
    localparam int MagW   = 2*COORD_BITS + 1;
    localparam int SqW    = 2*MagW;
    localparam int LenW   = SqW + 2;
    localparam int RemW   = LenW + 1;
    localparam int QuoW   = 2*NORMAL_FRAC_BITS + 3;
    localparam int SqrtW  = QuoW + 1;
    localparam int SqrtSt = SqrtW / 2;
    localparam int OutW   = NORMAL_FRAC_BITS + 2;
    localparam logic signed [OutW-1:0] QMax = OutW'(1) << NORMAL_FRAC_BITS;

    // divider stages
    logic [RemW-1:0] r_rem  [QuoW-1];
    logic [LenW-1:0] r_den  [QuoW-1];
    logic [QuoW-1:0] r_quo  [QuoW];
    t_lane_tag       r_dtag [QuoW];

    // square root stages
    logic [SqrtW-1:0] r_num  [SqrtSt-1];
    logic [SqrtW-1:0] r_res  [SqrtSt];
    t_lane_tag        r_stag [SqrtSt];

    // round / sign stage
    logic [OutW-1:0]         root;
    logic [OutW:0]           rsum;
    logic [OutW-1:0]         qmag;
    logic signed [OutW-1:0]  n_q;
    logic signed [OutW-1:0]  r_q;
    t_lane_tag               r_otag;

    for (genvar k = 0; k < QuoW; k++) begin : g_div
        logic [RemW-1:0] part;
        logic [LenW-1:0] den;
        logic [QuoW-1:0] quo_in;
        t_lane_tag       tag_in;
        logic            take;

        if (k == 0) begin : g_first
            // c^2 <= S, so the first bit is the integer part
            assign part   = RemW'(i_csq);
            assign den    = i_len_sq;
            assign quo_in = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign part   = {r_rem[k-1][RemW-2:0], 1'b0};
            assign den    = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign tag_in = r_dtag[k-1];
        end

        assign take   = part >= RemW'(den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dtag[k].valid <= 1'b0;
            end else if (i_advance) begin
                r_dtag[k] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_advance) begin
                r_quo[k] <= {quo_in[QuoW-2:0], take};
            end
        end

        if (k < QuoW-1) begin : g_keep
            logic [RemW-1:0] rem_nx;

            assign rem_nx = take ? (part - RemW'(den)) : part;

            always_ff @(posedge i_clk) begin
                if (i_advance) begin
                    r_rem[k] <= rem_nx;
                    r_den[k] <= den;
                end
            end
        end
    end

    for (genvar j = 0; j < SqrtSt; j++) begin : g_sqrt
        localparam logic [SqrtW-1:0] StepBit = SqrtW'(1) << (SqrtW - 2 - 2*j);
        logic [SqrtW-1:0] num_in;
        logic [SqrtW-1:0] res_in;
        t_lane_tag        tag_in;
        logic [SqrtW:0]   trial;
        logic             fits;
        logic [SqrtW-1:0] res_nx;

        if (j == 0) begin : g_first
            assign num_in = {1'b0, r_quo[QuoW-1]};
            assign res_in = '0;
            assign tag_in = r_dtag[QuoW-1];
        end else begin : g_next
            assign num_in = r_num[j-1];
            assign res_in = r_res[j-1];
            assign tag_in = r_stag[j-1];
        end

        assign trial  = {1'b0, res_in} + {1'b0, StepBit};
        assign fits   = {1'b0, num_in} >= trial;
        assign res_nx = fits ? ((res_in >> 1) + StepBit) : (res_in >> 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stag[j].valid <= 1'b0;
            end else if (i_advance) begin
                r_stag[j] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_advance) begin
                r_res[j] <= res_nx;
            end
        end

        if (j < SqrtSt-1) begin : g_keep
            logic [SqrtW-1:0] num_nx;

            assign num_nx = fits ? (num_in - trial[SqrtW-1:0]) : num_in;

            always_ff @(posedge i_clk) begin
                if (i_advance) begin
                    r_num[j] <= num_nx;
                end
            end
        end
    end

    // root <= 2^(F+1); halving after +1 rounds half away from zero
    always_comb begin
        root = r_res[SqrtSt-1][OutW-1:0];
        rsum = {1'b0, root} + (OutW+1)'(1);
        qmag = rsum[OutW:1];
        if (r_stag[SqrtSt-1].degen) begin
            n_q = '0;
        end else if (r_stag[SqrtSt-1].neg) begin
            n_q = -qmag;
        end else begin
            n_q = qmag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otag.valid <= 1'b0;
        end else if (i_advance) begin
            r_otag <= r_stag[SqrtSt-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_q <= n_q;
        end
    end

    assign o_tag = r_otag;
    assign o_q   = r_q;

    `TFN_ASSERT_NEXT(a_lane_hold, !i_advance, $stable(o_q) && $stable(o_tag), "lane moved while stalled")
    `TFN_ASSERT_IMPL(a_lane_range, o_tag.valid, (o_q <= QMax) && (o_q >= -QMax), "normal component out of range")

endmodule

// File: src/triangle_face_normal.sv
// Triangle face normal.
// i_tri takes one triangle per word: vertices a, b, c as signed fixed-point
// coordinates (Q8.8 at the default). o_norm gives one word per triangle:
// the unit normal of (b - a) x (c - a) as signed Q1.14 components rounded
// to nearest (ties away from zero), and a degenerate flag with a zero
// vector when the cross product is zero.
// Throughput: one triangle per cycle, no gaps while o_norm is taken.
// Pipeline: the front stages, then in each lane a divider (one quotient bit
// per stage), a square root (one root bit per stage) and a round stage.
// Words leave in the order they came in.
// Stall: the whole pipeline moves on one enable. Results land in a
// two-word output buffer; i_tri.ready drops only when that buffer is full,
// so the pipeline freezes and nothing is lost or repeated. i_tri.ready
// comes from a register, with no path from o_norm.ready.
// Reset (synchronous, active low) clears the valid bits and the output
// buffer; words in flight are dropped.
`include "triangle_face_normal_macros.svh"

module triangle_face_normal import tfn_pkg::*; #(
    parameter int COORD_BITS       = TFN_COORD_BITS,
    parameter int NORMAL_FRAC_BITS = TFN_NORMAL_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfn_tri_if.sink     i_tri,
    tfn_norm_if.source  o_norm
);
    localparam int EdgeW  = COORD_BITS + 1;
    localparam int ProdW  = 2*EdgeW;
    localparam int CrossW = ProdW + 1;
    localparam int MagW   = 2*COORD_BITS + 1;
    localparam int HalfW  = (MagW + 1) / 2;
    localparam int HiW    = MagW - HalfW;
    localparam int SqW    = 2*MagW;
    localparam int LenW   = SqW + 2;
    localparam int OutW   = NORMAL_FRAC_BITS + 2;
    localparam int BufW   = 3*OutW + 1;
    localparam int Depth  = 2;

    logic advance;          // whole pipe steps
    logic push;
    logic pop;

    // vertex coordinates by axis
    logic signed [COORD_BITS-1:0] va [3];
    logic signed [COORD_BITS-1:0] vb [3];
    logic signed [COORD_BITS-1:0] vc [3];

    // valid bits of the front stages (edges .. length squared)
    logic [5:0] r_vld;

    // stage 1: edges
    logic signed [EdgeW-1:0] n_e1 [3];
    logic signed [EdgeW-1:0] n_e2 [3];
    logic signed [EdgeW-1:0] r_e1 [3];
    logic signed [EdgeW-1:0] r_e2 [3];
    // stage 2: cross products, both terms
    logic signed [ProdW-1:0] r_pa [3];
    logic signed [ProdW-1:0] r_pb [3];
    // stage 3: magnitude and sign
    logic [MagW-1:0] r_mag  [3];
    logic            r_neg3 [3];
    // stage 4: square partial products
    logic [2*HiW-1:0]   r_hh   [3];
    logic [MagW-1:0]    r_hl   [3];
    logic [2*HalfW-1:0] r_ll   [3];
    logic               r_neg4 [3];
    logic               r_degen4;
    // stage 5: squares
    logic [SqW-1:0] r_csq5 [3];
    logic           r_neg5 [3];
    logic           r_degen5;
    // stage 6: squares and their sum
    logic [SqW-1:0]  r_csq6 [3];
    logic [LenW-1:0] r_len6;
    logic            r_neg6 [3];
    logic            r_degen6;

    t_lane_tag              lane_in  [3];
    t_lane_tag              lane_tag [3];
    logic signed [OutW-1:0] lane_q   [3];

    // output buffer
    logic [BufW-1:0] r_buf [Depth];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_count;
    logic [BufW-1:0] head;

    assign va[0] = i_tri.ax;
    assign va[1] = i_tri.ay;
    assign va[2] = i_tri.az;
    assign vb[0] = i_tri.bx;
    assign vb[1] = i_tri.by;
    assign vb[2] = i_tri.bz;
    assign vc[0] = i_tri.cx;
    assign vc[1] = i_tri.cy;
    assign vc[2] = i_tri.cz;

    assign advance     = (r_count != 2'(Depth));
    assign i_tri.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[4:0], i_tri.valid};
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_comp
        // cross component c = e1[j]*e2[k] - e1[k]*e2[j]
        localparam int J = (c + 1) % 3;
        localparam int K = (c + 2) % 3;
        logic signed [CrossW-1:0] cross_v;
        logic signed [CrossW-1:0] absv;
        logic [SqW-1:0]           csq;
        logic [HiW-1:0]           mhi;
        logic [HalfW-1:0]         mlo;

        assign n_e1[c] = {vb[c][COORD_BITS-1], vb[c]} - {va[c][COORD_BITS-1], va[c]};
        assign n_e2[c] = {vc[c][COORD_BITS-1], vc[c]} - {va[c][COORD_BITS-1], va[c]};

        assign cross_v = CrossW'(r_pa[c]) - CrossW'(r_pb[c]);
        assign absv    = cross_v[CrossW-1] ? -cross_v : cross_v;

        // magnitude split into high and low halves for the square
        assign mhi = r_mag[c][MagW-1:HalfW];
        assign mlo = r_mag[c][HalfW-1:0];

        // c^2 = hh*2^(2h) + 2*hl*2^h + ll
        assign csq = (SqW'(r_hh[c]) << (2*HalfW)) + (SqW'(r_hl[c]) << (HalfW + 1))
                   + SqW'(r_ll[c]);

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_e1[c]   <= n_e1[c];
                r_e2[c]   <= n_e2[c];
                r_pa[c]   <= ProdW'(r_e1[J]) * ProdW'(r_e2[K]);
                r_pb[c]   <= ProdW'(r_e1[K]) * ProdW'(r_e2[J]);
                r_mag[c]  <= absv[MagW-1:0];
                r_neg3[c] <= cross_v[CrossW-1];
                r_hh[c]   <= (2*HiW)'(mhi) * (2*HiW)'(mhi);
                r_hl[c]   <= MagW'(mhi) * MagW'(mlo);
                r_ll[c]   <= (2*HalfW)'(mlo) * (2*HalfW)'(mlo);
                r_neg4[c] <= r_neg3[c];
                r_csq5[c] <= csq;
                r_neg5[c] <= r_neg4[c];
                r_csq6[c] <= r_csq5[c];
                r_neg6[c] <= r_neg5[c];
            end
        end

        assign lane_in[c] = '{valid: r_vld[5], neg: r_neg6[c], degen: r_degen6};

        tfn_norm_lane #(
            .COORD_BITS       (COORD_BITS),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_tag     (lane_in[c]),
            .i_csq     (r_csq6[c]),
            .i_len_sq  (r_len6),
            .o_tag     (lane_tag[c]),
            .o_q       (lane_q[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_degen4 <= (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
            r_degen5 <= r_degen4;
            r_degen6 <= r_degen5;
            r_len6   <= LenW'(r_csq5[0]) + LenW'(r_csq5[1]) + LenW'(r_csq5[2]);
        end
    end

    // output buffer: two words, so ready never waits on o_norm.ready
    assign push = advance && lane_tag[0].valid;
    assign pop  = o_norm.valid && o_norm.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= {lane_tag[0].degen, lane_q[0], lane_q[1], lane_q[2]};
        end
    end

    assign head              = r_buf[r_rp];
    assign o_norm.valid      = (r_count != '0);
    assign o_norm.degenerate = head[3*OutW];
    assign o_norm.nx         = head[3*OutW-1 -: OutW];
    assign o_norm.ny         = head[2*OutW-1 -: OutW];
    assign o_norm.nz         = head[OutW-1:0];

    `TFN_ASSERT_IMPL(a_buf_ptrs, 1'b1, (r_wp ^ r_rp) == r_count[0], "buffer pointers disagree with fill")
    `TFN_ASSERT_IMPL(a_degen_zero, o_norm.valid && o_norm.degenerate, (o_norm.nx == '0) && (o_norm.ny == '0) && (o_norm.nz == '0), "degenerate word with nonzero normal")
    `TFN_ASSERT_IMPL(a_lanes_step, 1'b1, (lane_tag[0].valid == lane_tag[1].valid) && (lane_tag[0].valid == lane_tag[2].valid), "normalize lanes out of step")

endmodule
